### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the display scan driver. They assume
// the clock is clk_i and the active-low reset is rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_RST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sssd_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment scan driver package
// Command codes, segment patterns and constants shared by the driver files.
// ---------------------------------------------------------------------------
package sssd_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_NUMBER  = 2'd1,
    REQ_SUCCESS = 2'd2,
    REQ_FAIL    = 2'd3
  } req_type_e;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned DwellWidth = 16;
  localparam int unsigned NumWidth   = 14;

  localparam logic [DwellWidth-1:0] DWELL_RESET = 16'd10;
  localparam logic [NumWidth-1:0]   NUM_MAX     = 14'd9999;
  localparam logic [7:0]            SEG_BLANK   = 8'hFF;
  localparam logic [7:0]            SEG_DOT     = 8'h7F;

  // Success pass has one extra step: the dot on the last digit.
  localparam logic [2:0] STEPS_NORMAL  = 3'd4;
  localparam logic [2:0] STEPS_SUCCESS = 3'd5;
  localparam logic [2:0] SUCC_LAST     = 3'd4;

  // Active-low decimal digit patterns; values above nine are blank.
  function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // S U C C, then the dot.
  function automatic logic [7:0] seg_of_succ(input logic [2:0] idx);
    logic [7:0] s;
    case (idx)
      3'd0:    s = 8'h92;
      3'd1:    s = 8'hC1;
      3'd2:    s = 8'hC6;
      3'd3:    s = 8'hC6;
      default: s = SEG_DOT;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] pos_of_succ(input logic [2:0] idx);
    logic [3:0] p;
    case (idx)
      3'd0:    p = 4'b0001;
      3'd1:    p = 4'b0010;
      3'd2:    p = 4'b0100;
      default: p = 4'b1000;
    endcase
    return p;
  endfunction

  // F A I L.
  function automatic logic [7:0] seg_of_fail(input logic [1:0] idx);
    logic [7:0] s;
    case (idx)
      2'd0:    s = 8'h8E;
      2'd1:    s = 8'h88;
      2'd2:    s = 8'hCF;
      default: s = 8'hC7;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/sssd_cmd_if.sv
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one display command per transaction.
// ---------------------------------------------------------------------------
interface sssd_cmd_if;

  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [13:0] number;

  modport source (output valid, output req_type, output number, input ready);
  modport sink   (input valid, input req_type, input number, output ready);

endinterface

### rtl/core/sssd_res_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the display drive state after each command.
// ---------------------------------------------------------------------------
interface sssd_res_if;

  logic       valid;
  logic       ready;
  logic [3:0] digit_enable;
  logic [7:0] segments;
  logic       busy_res;

  modport source (output valid, output digit_enable, output segments, output busy_res,
                  input ready);
  modport sink   (input valid, input digit_enable, input segments, input busy_res,
                  output ready);

endinterface

### rtl/core/seven_segment_scan_driver.sv
// ---------------------------------------------------------------------------
// Seven-segment scan driver
// Each transaction on cmd_i is one event: a tick, or a command to show a
// number, the success message or the fail message on a 4-digit
// common-anode display. Each accepted transaction yields exactly one result
// transaction on res_o with the one-hot digit enable, the active-low
// segments and the busy flag as they stand after the event. A command starts
// a scan pass: segments blank to 0xFF, then each tick advances the pass,
// enabling one digit for dwell_ticks ticks per step (a dwell of 0 acts as 1).
// Numbers above 9999 saturate. A command given during a pass restarts it.
// The block accepts one transaction every clock cycle while res_o takes its
// results; a result passes through the decimal split register and then the
// state and result register. dwell_ticks (reset 10) must be written through
// cfg_we_i/cfg_wdata_i only while no transaction is in flight; the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module seven_segment_scan_driver
  import sssd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DwellWidth-1:0] cfg_wdata_i,
  sssd_cmd_if.sink              cmd_i,
  sssd_res_if.source            res_o
);

  // Reciprocal multipliers for the decimal split. For values up to 9999 the
  // truncation error of each stays well below the smallest gap to the next
  // integer, so the quotients come out exact.
  localparam logic [13:0] Q1000_MUL = 14'd8389;   // 2^23 / 1000, rounded up
  localparam logic [13:0] Q100_MUL  = 14'd5243;   // 2^19 / 100, rounded up
  localparam logic [13:0] Q10_MUL   = 14'd6554;   // 2^16 / 10, rounded up

  // -------------------------------------------------------------------------
  // Configuration register.
  // -------------------------------------------------------------------------
  logic [DwellWidth-1:0] dwell_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= DWELL_RESET;
    end else if (cfg_we_i) begin
      dwell_ticks_q <= cfg_wdata_i;
    end
  end

  // -------------------------------------------------------------------------
  // Handshake. The input register advances into the state/result register
  // whenever the result register is empty or being drained, so a stalled
  // sink holds at most one finished result while one more command waits.
  // -------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic cmd_acc;
  logic s1_move;

  assign s1_move     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !s1_valid_q || s1_move;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  assign s1_valid_d  = cmd_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_move ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // -------------------------------------------------------------------------
  // Input register: saturate the number and form the three decimal
  // quotients with constant multiplies, so that the state update only has
  // short subtractions left.
  // -------------------------------------------------------------------------
  logic [NumWidth-1:0] num_sat;
  logic [27:0]         prod1000;
  logic [27:0]         prod100;
  logic [27:0]         prod10;

  req_type_e           s1_req_q;
  logic [NumWidth-1:0] s1_num_q;
  logic [3:0]          s1_q1000_q;
  logic [6:0]          s1_q100_q;
  logic [9:0]          s1_q10_q;

  assign num_sat  = (cmd_i.number > NUM_MAX) ? NUM_MAX : cmd_i.number;
  assign prod1000 = 28'(num_sat) * 28'(Q1000_MUL);
  assign prod100  = 28'(num_sat) * 28'(Q100_MUL);
  assign prod10   = 28'(num_sat) * 28'(Q10_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      s1_req_q   <= req_type_e'(cmd_i.req_type);
      s1_num_q   <= num_sat;
      s1_q1000_q <= prod1000[26:23];
      s1_q100_q  <= prod100[25:19];
      s1_q10_q   <= prod10[25:16];
    end
  end

  // Remainders: each lower digit is a quotient less ten times the coarser one.
  logic [6:0]          q1000_x10;
  logic [9:0]          q100_x10;
  logic [NumWidth-1:0] q10_x10;
  logic [6:0]          rem1;
  logic [9:0]          rem2;
  logic [NumWidth-1:0] rem3;
  logic [3:0]          split_digits [NumDigits];

  assign q1000_x10 = 7'({s1_q1000_q, 3'b000}) + 7'({s1_q1000_q, 1'b0});
  assign q100_x10  = 10'({s1_q100_q, 3'b000}) + 10'({s1_q100_q, 1'b0});
  assign q10_x10   = 14'({s1_q10_q, 3'b000}) + 14'({s1_q10_q, 1'b0});
  assign rem1      = s1_q100_q - q1000_x10;
  assign rem2      = s1_q10_q - q100_x10;
  assign rem3      = s1_num_q - q10_x10;

  assign split_digits[0] = s1_q1000_q;
  assign split_digits[1] = rem1[3:0];
  assign split_digits[2] = rem2[3:0];
  assign split_digits[3] = rem3[3:0];

  // -------------------------------------------------------------------------
  // Scan state. The display registers double as the result payload: they
  // only change when a new result enters, and the next result only enters
  // once the current one has been taken.
  // -------------------------------------------------------------------------
  req_type_e             pass_mode_q, pass_mode_d;
  logic [3:0]            digit_val_q [NumDigits];
  logic [3:0]            digit_val_d [NumDigits];
  logic [2:0]            scan_step_q, scan_step_d;
  logic [DwellWidth-1:0] dwell_cnt_q, dwell_cnt_d;
  logic [7:0]            seg_q, seg_d;
  logic [3:0]            dig_q, dig_d;
  logic                  busy_q, busy_d;

  logic [DwellWidth-1:0] dwell_eff;
  logic [DwellWidth-1:0] cnt_loaded;
  logic [2:0]            step_inc;
  logic [2:0]            steps_in_pass;
  logic [2:0]            succ_idx;
  logic [1:0]            pos_idx;
  logic [7:0]            load_seg;
  logic [3:0]            load_dig;

  assign dwell_eff     = (dwell_ticks_q == '0) ? DwellWidth'(1) : dwell_ticks_q;
  assign steps_in_pass = (pass_mode_q == REQ_SUCCESS) ? STEPS_SUCCESS : STEPS_NORMAL;
  assign succ_idx      = (scan_step_q > SUCC_LAST) ? SUCC_LAST : scan_step_q;
  assign pos_idx       = scan_step_q[1:0];
  assign step_inc      = scan_step_q + 3'd1;

  // Pattern that the current step puts on the display.
  always_comb begin
    load_dig = 4'b0001 << pos_idx;
    case (pass_mode_q)
      REQ_SUCCESS: begin
        load_dig = pos_of_succ(succ_idx);
        load_seg = seg_of_succ(succ_idx);
      end
      REQ_FAIL: begin
        load_seg = seg_of_fail(pos_idx);
      end
      default: begin
        load_seg = seg_of_digit(digit_val_q[pos_idx]);
      end
    endcase
  end

  always_comb begin
    pass_mode_d = pass_mode_q;
    digit_val_d = digit_val_q;
    scan_step_d = scan_step_q;
    dwell_cnt_d = dwell_cnt_q;
    seg_d       = seg_q;
    dig_d       = dig_q;
    busy_d      = busy_q;
    cnt_loaded  = (dwell_cnt_q == '0) ? dwell_eff : dwell_cnt_q;

    if (s1_req_q != REQ_TICK) begin
      // Any command (re)starts a pass with a blank display; the enabled
      // digit stays where it was.
      pass_mode_d = s1_req_q;
      if (s1_req_q == REQ_NUMBER) begin
        digit_val_d = split_digits;
      end
      scan_step_d = '0;
      dwell_cnt_d = '0;
      seg_d       = SEG_BLANK;
      busy_d      = 1'b1;
    end else if (busy_q) begin
      // A step is put on the display on the first tick of its dwell.
      if (dwell_cnt_q == '0) begin
        seg_d = load_seg;
        dig_d = load_dig;
      end
      dwell_cnt_d = cnt_loaded - DwellWidth'(1);
      if (dwell_cnt_d == '0) begin
        scan_step_d = step_inc;
        if (step_inc >= steps_in_pass) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_mode_q <= REQ_TICK;
      for (int i = 0; i < NumDigits; i++) begin
        digit_val_q[i] <= '0;
      end
      scan_step_q <= '0;
      dwell_cnt_q <= '0;
      seg_q       <= SEG_BLANK;
      dig_q       <= '0;
      busy_q      <= 1'b0;
    end else if (s1_move) begin
      pass_mode_q <= pass_mode_d;
      digit_val_q <= digit_val_d;
      scan_step_q <= scan_step_d;
      dwell_cnt_q <= dwell_cnt_d;
      seg_q       <= seg_d;
      dig_q       <= dig_d;
      busy_q      <= busy_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.digit_enable = dig_q;
  assign res_o.segments     = seg_q;
  assign res_o.busy_res     = busy_q;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `ASSERT_RST(a_digit_onehot0, $onehot0(dig_q), "more than one digit enabled")
  `ASSERT_RST(a_idle_no_dwell, !busy_q |-> (dwell_cnt_q == '0),
              "dwell counter left running at end of pass")
  `ASSERT_RST_NEXT(a_cmd_blanks, s1_move && (s1_req_q != REQ_TICK),
                   busy_q && (seg_q == SEG_BLANK) && (scan_step_q == '0),
                   "command did not restart the pass blanked")

endmodule
